// ----- rtl/core/pse_pkg.sv -----
`timescale 1ns / 1ps

package pse_pkg;

	localparam int OPCODE_W = 3;
	localparam int STATUS_W = 2;
	localparam int DATA_W   = 32;

	localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_END  = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_EXPR = 2'd1,
		ST_DIVZ = 2'd2,
		ST_OVF  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		U_FETCH   = 5'd0,
		U_DECODE  = 5'd1,
		U_PUSH    = 5'd2,
		U_EM_OVF  = 5'd3,
		U_RD_OK   = 5'd4,
		U_EM_OK   = 5'd5,
		U_RD_EXPR = 5'd6,
		U_EM_EXPR = 5'd7,
		U_EM_ZERO = 5'd8,
		U_ARITH   = 5'd9,
		U_RD2     = 5'd10,
		U_LDA     = 5'd11,
		U_ADD     = 5'd12,
		U_SUB     = 5'd13,
		U_MINIT   = 5'd14,
		U_MSTEP   = 5'd15,
		U_DINIT   = 5'd16,
		U_DSTEP   = 5'd17,
		U_DFIN    = 5'd18,
		U_WB      = 5'd19,
		U_EM_DIVZ = 5'd20
	} upc_t;

	typedef enum logic [2:0] {
		SQ_JUMP    = 3'd0,
		SQ_FETCH   = 3'd1,
		SQ_MAP_DEC = 3'd2,
		SQ_MAP_EXE = 3'd3,
		SQ_LOOP    = 3'd4,
		SQ_EMIT    = 3'd5
	} seq_t;

	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_PUSH = 2'd1,
		WR_RES  = 2'd2
	} wr_t;

	typedef enum logic [1:0] {
		DEP_HOLD = 2'd0,
		DEP_INC  = 2'd1,
		DEP_DEC  = 2'd2
	} dep_t;

	typedef enum logic {
		RS_TOP    = 1'b0,
		RS_SECOND = 1'b1
	} rsel_t;

	typedef enum logic [3:0] {
		DP_NONE  = 4'd0,
		DP_LDB   = 4'd1,
		DP_LDA   = 4'd2,
		DP_ADD   = 4'd3,
		DP_SUB   = 4'd4,
		DP_MINIT = 4'd5,
		DP_MSTEP = 4'd6,
		DP_DINIT = 4'd7,
		DP_DSTEP = 4'd8,
		DP_DFIN  = 4'd9
	} dp_t;

	typedef enum logic [1:0] {
		VS_OPND  = 2'd0,
		VS_RDATA = 2'd1,
		VS_ZERO  = 2'd2,
		VS_A     = 2'd3
	} vsel_t;

	typedef struct packed {
		seq_t    seq;
		upc_t    target;
		logic    rd_en;
		rsel_t   rsel;
		wr_t     wr;
		dep_t    dep;
		dp_t     dp;
		vsel_t   vsel;
		status_t status;
	} uword_t;

	function automatic uword_t ucode_rom(upc_t addr);
		uword_t w;
		w.seq    = SQ_JUMP;
		w.target = U_FETCH;
		w.rd_en  = 1'b0;
		w.rsel   = RS_TOP;
		w.wr     = WR_NONE;
		w.dep    = DEP_HOLD;
		w.dp     = DP_NONE;
		w.vsel   = VS_ZERO;
		w.status = ST_OK;
		case (addr)
			U_FETCH: begin
				w.seq    = SQ_FETCH;
				w.target = U_DECODE;
			end
			U_DECODE: begin
				w.seq = SQ_MAP_DEC;
			end
			U_PUSH: begin
				w.wr  = WR_PUSH;
				w.dep = DEP_INC;
			end
			U_EM_OVF: begin
				w.seq    = SQ_EMIT;
				w.vsel   = VS_OPND;
				w.status = ST_OVF;
			end
			U_RD_OK: begin
				w.rd_en  = 1'b1;
				w.target = U_EM_OK;
			end
			U_EM_OK: begin
				w.seq    = SQ_EMIT;
				w.vsel   = VS_RDATA;
				w.status = ST_OK;
			end
			U_RD_EXPR: begin
				w.rd_en  = 1'b1;
				w.target = U_EM_EXPR;
			end
			U_EM_EXPR: begin
				w.seq    = SQ_EMIT;
				w.vsel   = VS_RDATA;
				w.status = ST_EXPR;
			end
			U_EM_ZERO: begin
				w.seq    = SQ_EMIT;
				w.vsel   = VS_ZERO;
				w.status = ST_EXPR;
			end
			U_ARITH: begin
				w.rd_en  = 1'b1;
				w.target = U_RD2;
			end
			U_RD2: begin
				w.rd_en  = 1'b1;
				w.rsel   = RS_SECOND;
				w.dp     = DP_LDB;
				w.target = U_LDA;
			end
			U_LDA: begin
				w.seq = SQ_MAP_EXE;
				w.dp  = DP_LDA;
			end
			U_ADD: begin
				w.dp     = DP_ADD;
				w.target = U_WB;
			end
			U_SUB: begin
				w.dp     = DP_SUB;
				w.target = U_WB;
			end
			U_MINIT: begin
				w.dp     = DP_MINIT;
				w.target = U_MSTEP;
			end
			U_MSTEP: begin
				w.seq    = SQ_LOOP;
				w.dp     = DP_MSTEP;
				w.target = U_WB;
			end
			U_DINIT: begin
				w.dp     = DP_DINIT;
				w.target = U_DSTEP;
			end
			U_DSTEP: begin
				w.seq    = SQ_LOOP;
				w.dp     = DP_DSTEP;
				w.target = U_DFIN;
			end
			U_DFIN: begin
				w.dp     = DP_DFIN;
				w.target = U_WB;
			end
			U_WB: begin
				w.wr  = WR_RES;
				w.dep = DEP_DEC;
			end
			U_EM_DIVZ: begin
				w.seq    = SQ_EMIT;
				w.vsel   = VS_A;
				w.status = ST_DIVZ;
			end
			default: begin
				w.seq    = SQ_JUMP;
				w.target = U_FETCH;
			end
		endcase
		return w;
	endfunction

	function automatic upc_t map_decode(logic [OPCODE_W-1:0] op, logic empty, logic one,
			logic full);
		upc_t t;
		t = U_FETCH;
		case (op)
			OP_PUSH: t = full ? U_EM_OVF : U_PUSH;
			OP_END: begin
				if (empty)
					t = U_EM_ZERO;
				else if (one)
					t = U_RD_OK;
				else
					t = U_RD_EXPR;
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (empty)
					t = U_EM_ZERO;
				else if (one)
					t = U_RD_EXPR;
				else
					t = U_ARITH;
			end
			default: t = U_FETCH;
		endcase
		return t;
	endfunction

	function automatic upc_t map_execute(logic [OPCODE_W-1:0] op, logic b_zero);
		upc_t t;
		t = U_FETCH;
		case (op)
			OP_ADD: t = U_ADD;
			OP_SUB: t = U_SUB;
			OP_MUL: t = U_MINIT;
			OP_DIV: t = b_zero ? U_EM_DIVZ : U_DINIT;
			default: t = U_FETCH;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/core/postfix_stack_evaluator.sv -----
`timescale 1ns / 1ps
// Postfix integer expression evaluator on an operand stack.
// Input channel s_axis: tuser carries the opcode (push, add, subtract, multiply,
// divide, end), tdata the signed 32-bit operand used by push.
// Output channel m_axis: tuser carries the status (result, expression error,
// divide by zero, overflow), tdata the 32-bit value.
// Only the end token and errors produce a transfer on m_axis; the stack empties
// after every result. Push onto a full stack reports overflow and drops the operand.
// A microcoded sequencer steps once per clock, save while it waits for a token or
// for m_axis_tready, and drives a single-ported stack memory with registered read.
// Multiply works by shift-add, one bit a cycle;
// divide by restoring division, one quotient bit a cycle.
// s_axis_tready is high only while the sequencer waits for a token.
// A result sits in an output register; the next token is taken while it waits.
// If m_axis_tready stays low, the sequencer holds at its next emitting step.
// Reset empties the stack and the output register; stack contents are not cleared.
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [pse_pkg::DATA_W-1:0]     s_axis_tdata,  // [31:0] operand
	input  logic [pse_pkg::OPCODE_W-1:0]   s_axis_tuser,  // [2:0] opcode
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [pse_pkg::DATA_W-1:0]     m_axis_tdata,  // [31:0] value
	output logic [pse_pkg::STATUS_W-1:0]   m_axis_tuser   // [1:0] status
);
	import pse_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	upc_t   upc_q;
	upc_t   upc_next;
	uword_t cw;

	logic [DW-1:0]       depth_q;
	logic [DW-1:0]       depth_m1;
	logic [DW-1:0]       depth_m2;
	logic [OPCODE_W-1:0] opcode_q;
	logic [DATA_W-1:0]   operand_q;

	logic [W-1:0]  stack_q [STACK_DEPTH];
	logic [W-1:0]  rdata_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [W-1:0]  wdata;

	logic [63:0]   opnd_64;
	logic [W-1:0]  opnd_w;
	logic [W-1:0]  val_w;
	logic [63:0]   val_64;

	logic          m_valid_q;
	status_t       m_status_q;
	logic [DATA_W-1:0] m_value_q;

	logic          out_free;
	logic          emit_fire;
	logic          in_xfer;
	logic          empty;
	logic          one;
	logic          full;

	logic [W-1:0]  alu_a;
	logic [W-1:0]  alu_r;
	logic          alu_bzero;
	logic          alu_last;

	pse_alu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.dp     (cw.dp),
		.rdata  (rdata_q),
		.a      (alu_a),
		.result (alu_r),
		.b_zero (alu_bzero),
		.last   (alu_last)
	);

	assign cw = ucode_rom(upc_q);

	assign depth_m1 = depth_q - DW'(1);
	assign depth_m2 = depth_q - DW'(2);
	assign empty    = (depth_q == '0);
	assign one      = (depth_q == DW'(1));
	assign full     = (depth_q == DW'(STACK_DEPTH));

	assign s_axis_tready = (cw.seq == SQ_FETCH);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~m_valid_q | m_axis_tready;
	assign emit_fire     = (cw.seq == SQ_EMIT) & out_free;

	assign opnd_64 = {{32{operand_q[DATA_W-1]}}, operand_q};
	assign opnd_w  = opnd_64[W-1:0];

	assign raddr = (cw.rsel == RS_SECOND) ? depth_m2[AW-1:0] : depth_m1[AW-1:0];
	assign waddr = (cw.wr == WR_PUSH) ? depth_q[AW-1:0] : depth_m2[AW-1:0];
	assign wdata = (cw.wr == WR_PUSH) ? opnd_w : alu_r;

	always_comb begin
		case (cw.vsel)
			VS_OPND:  val_w = opnd_w;
			VS_RDATA: val_w = rdata_q;
			VS_A:     val_w = alu_a;
			default:  val_w = '0;
		endcase
	end

	assign val_64 = 64'(val_w);

	always_comb begin
		case (cw.seq)
			SQ_JUMP:    upc_next = cw.target;
			SQ_FETCH:   upc_next = s_axis_tvalid ? cw.target : upc_q;
			SQ_MAP_DEC: upc_next = map_decode(opcode_q, empty, one, full);
			SQ_MAP_EXE: upc_next = map_execute(opcode_q, alu_bzero);
			SQ_LOOP:    upc_next = alu_last ? cw.target : upc_q;
			SQ_EMIT:    upc_next = out_free ? cw.target : upc_q;
			default:    upc_next = U_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q     <= U_FETCH;
			depth_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_next;
			if (emit_fire) begin
				depth_q <= '0;
			end else begin
				case (cw.dep)
					DEP_INC: depth_q <= depth_q + DW'(1);
					DEP_DEC: depth_q <= depth_m1;
					default: depth_q <= depth_q;
				endcase
			end
			if (emit_fire)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_q  <= s_axis_tuser;
			operand_q <= s_axis_tdata;
		end
		if (emit_fire) begin
			m_status_q <= cw.status;
			m_value_q  <= val_64[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cw.wr != WR_NONE)
			stack_q[waddr] <= wdata;
		if (cw.rd_en)
			rdata_q <= stack_q[raddr];
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_value_q;
	assign m_axis_tuser  = m_status_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (depth_q == '0) && m_valid_q)
		else $error("result transfer did not empty the stack");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.wr == WR_PUSH) |-> !full)
		else $error("push written into a full stack");

	a_wb_two: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.wr == WR_RES) |-> (depth_q >= DW'(2)))
		else $error("operator result written with fewer than two entries");
`endif

endmodule

// ----- rtl/core/pse_alu.sv -----
`timescale 1ns / 1ps

module pse_alu #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pse_pkg::dp_t           dp,
	input  logic [VALUE_WIDTH-1:0] rdata,
	output logic [VALUE_WIDTH-1:0] a,
	output logic [VALUE_WIDTH-1:0] result,
	output logic                   b_zero,
	output logic                   last
);
	import pse_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(VALUE_WIDTH);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  r_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;

	logic [W:0]    shifted;
	logic [W+1:0]  diff;
	logic          ge;

	assign shifted = {r_q, a_q[W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, b_q};
	assign ge      = ~diff[W+1];

	assign a      = a_q;
	assign result = r_q;
	assign b_zero = (b_q == '0);
	assign last   = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (dp)
				DP_MINIT, DP_DINIT: cnt_q <= CW'(W - 1);
				DP_MSTEP, DP_DSTEP: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (dp)
			DP_LDB: b_q <= rdata;
			DP_LDA: a_q <= rdata;
			DP_ADD: r_q <= a_q + b_q;
			DP_SUB: r_q <= a_q - b_q;
			DP_MINIT: r_q <= '0;
			DP_MSTEP: begin
				if (b_q[0])
					r_q <= r_q + a_q;
				a_q <= {a_q[W-2:0], 1'b0};
				b_q <= {1'b0, b_q[W-1:1]};
			end
			DP_DINIT: begin
				a_q   <= a_q[W-1] ? (W'(0) - a_q) : a_q;
				b_q   <= b_q[W-1] ? (W'(0) - b_q) : b_q;
				neg_q <= a_q[W-1] ^ b_q[W-1];
				r_q   <= '0;
			end
			DP_DSTEP: begin
				r_q <= ge ? diff[W-1:0] : shifted[W-1:0];
				a_q <= {a_q[W-2:0], ge};
			end
			DP_DFIN: r_q <= neg_q ? (W'(0) - a_q) : a_q;
			default: r_q <= r_q;
		endcase
	end

endmodule
